[hw/rtl/swtc_pkg.sv]
// ============================================================================
// swtc_pkg
// Shared types, fixed word table and character helpers for the SQL word
// token classifier.
// ============================================================================
package swtc_pkg;

    // Width of the offset and length counters (saturating)
    localparam int OFFSET_BITS = 16;
    // Width of the start and length fields on the result word
    localparam int FIELD_BITS  = 16;
    localparam int NUM_FIXED   = 12;
    localparam int FW_BYTES    = 8;
    localparam int FW_POS_BITS = $clog2(FW_BYTES);

    localparam logic [7:0] QUOTE_BYTE = 8'h27;
    localparam logic [7:0] USCORE_BYTE = 8'h5F;

    typedef enum logic [3:0] {
        KIND_SELECT  = 4'd0,
        KIND_FROM    = 4'd1,
        KIND_WHERE   = 4'd2,
        KIND_COLUMN  = 4'd3,
        KIND_LITERAL = 4'd4,
        KIND_OPER    = 4'd5,
        KIND_AND     = 4'd6,
        KIND_OR      = 4'd7,
        KIND_BETWEEN = 4'd8,
        KIND_UNKNOWN = 4'd9
    } token_kind_t;

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [FIELD_BITS-1:0]  field_t;

    // Fixed words, first character in the lowest byte
    localparam logic [8*FW_BYTES-1:0] FW_TEXT [NUM_FIXED] = '{
        64'h0000_5443_454C_4553,   // SELECT
        64'h0000_0000_4D4F_5246,   // FROM
        64'h0000_0045_5245_4857,   // WHERE
        64'h0000_0000_0044_4E41,   // AND
        64'h0000_0000_0000_524F,   // OR
        64'h004E_4545_5754_4542,   // BETWEEN
        64'h0000_0000_0000_003D,   // =
        64'h0000_0000_0000_003E,   // >
        64'h0000_0000_0000_3D3E,   // >=
        64'h0000_0000_0000_003C,   // <
        64'h0000_0000_0000_3D3C,   // <=
        64'h0000_0000_0000_3D21    // !=
    };

    localparam logic [FW_POS_BITS:0] FW_LEN [NUM_FIXED] = '{
        4'd6, 4'd4, 4'd5, 4'd3, 4'd2, 4'd7, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd2
    };

    localparam token_kind_t FW_KIND [NUM_FIXED] = '{
        KIND_SELECT, KIND_FROM, KIND_WHERE, KIND_AND, KIND_OR, KIND_BETWEEN,
        KIND_OPER, KIND_OPER, KIND_OPER, KIND_OPER, KIND_OPER, KIND_OPER
    };

    // Result of one byte step
    typedef struct packed {
        logic        emit;
        token_kind_t kind;
        logic        present;
        field_t      start;
        field_t      length;
        logic        done;
    } swtc_result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A)) || (c == USCORE_BYTE);
    endfunction

    function automatic offset_t sat_inc(input offset_t v);
        return (v == {OFFSET_BITS{1'b1}}) ? v : v + offset_t'(1);
    endfunction

    // Clip a counter value to the result field width
    function automatic field_t clip_field(input offset_t v);
        logic [OFFSET_BITS+FIELD_BITS-1:0] w;
        w = {{FIELD_BITS{1'b0}}, v};
        if (w > (OFFSET_BITS+FIELD_BITS)'({FIELD_BITS{1'b1}}))
            return {FIELD_BITS{1'b1}};
        return w[FIELD_BITS-1:0];
    endfunction

endpackage

[hw/rtl/swtc_scan.sv]
// ============================================================================
// swtc_scan
// Per-byte word state, keyword candidate tracking and word classification.
// ============================================================================
module swtc_scan
    import swtc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   char_byte,
    input  logic         end_of_text,
    output swtc_result_t result
);

    offset_t                byte_offset_reg, byte_offset_next;
    logic                   in_word_reg, in_word_next;
    offset_t                word_begin_reg, word_begin_next;
    offset_t                word_len_reg, word_len_next;
    logic [NUM_FIXED-1:0]   cand_reg, cand_next;
    logic                   all_word_reg, all_word_next;
    logic                   first_quote_reg, first_quote_next;
    logic                   latest_quote_reg, latest_quote_next;

    // State after the byte joins the word
    logic                   sp;
    logic                   in_word_a;
    offset_t                begin_a;
    offset_t                len_a;
    logic [NUM_FIXED-1:0]   cand_a;
    logic                   all_word_a;
    logic                   first_quote_a;
    logic                   latest_quote_a;
    logic                   emit_word;
    logic                   found;
    token_kind_t            kind;
    logic [FW_POS_BITS-1:0] pos;

    always_comb
    begin
        sp             = is_space(char_byte);
        pos            = word_len_reg[FW_POS_BITS-1:0];
        in_word_a      = in_word_reg;
        begin_a        = word_begin_reg;
        len_a          = word_len_reg;
        cand_a         = cand_reg;
        all_word_a     = all_word_reg;
        first_quote_a  = first_quote_reg;
        latest_quote_a = latest_quote_reg;
        if (!sp)
        begin
            if (!in_word_reg)
            begin
                in_word_a     = 1'b1;
                begin_a       = byte_offset_reg;
                first_quote_a = (char_byte == QUOTE_BYTE);
            end
            for (int i = 0; i < NUM_FIXED; i++)
            begin
                if ((word_len_reg >= offset_t'(FW_LEN[i])) ||
                    (FW_TEXT[i][{pos, 3'b000} +: 8] != char_byte))
                    cand_a[i] = 1'b0;
            end
            if (!is_word_char(char_byte))
                all_word_a = 1'b0;
            latest_quote_a = (char_byte == QUOTE_BYTE);
            len_a          = sat_inc(word_len_reg);
        end
    end

    // Classify: fixed words first, in table order
    always_comb
    begin
        found = 1'b0;
        kind  = KIND_UNKNOWN;
        for (int i = 0; i < NUM_FIXED; i++)
        begin
            if (!found && cand_a[i] && (len_a == offset_t'(FW_LEN[i])))
            begin
                found = 1'b1;
                kind  = FW_KIND[i];
            end
        end
        if (!found)
        begin
            if (all_word_a)
                kind = KIND_COLUMN;
            else if (first_quote_a && latest_quote_a)
                kind = KIND_LITERAL;
            else
                kind = KIND_UNKNOWN;
        end
    end

    always_comb
    begin
        emit_word = in_word_a && (sp || end_of_text);
        result.emit = emit_word || end_of_text;
        result.done = end_of_text;
        if (emit_word)
        begin
            result.kind    = kind;
            result.present = 1'b1;
            result.start   = clip_field(begin_a);
            result.length  = clip_field(len_a);
        end
        else
        begin
            result.kind    = KIND_SELECT;
            result.present = 1'b0;
            result.start   = '0;
            result.length  = '0;
        end
    end

    always_comb
    begin
        byte_offset_next  = sat_inc(byte_offset_reg);
        in_word_next      = in_word_a;
        word_begin_next   = begin_a;
        word_len_next     = len_a;
        cand_next         = cand_a;
        all_word_next     = all_word_a;
        first_quote_next  = first_quote_a;
        latest_quote_next = latest_quote_a;
        if (emit_word || end_of_text)
        begin
            in_word_next      = 1'b0;
            word_begin_next   = '0;
            word_len_next     = '0;
            cand_next         = '1;
            all_word_next     = 1'b1;
            first_quote_next  = 1'b0;
            latest_quote_next = 1'b0;
        end
        if (end_of_text)
            byte_offset_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg  <= '0;
            in_word_reg      <= 1'b0;
            word_begin_reg   <= '0;
            word_len_reg     <= '0;
            cand_reg         <= '1;
            all_word_reg     <= 1'b1;
            first_quote_reg  <= 1'b0;
            latest_quote_reg <= 1'b0;
        end
        else if (step)
        begin
            byte_offset_reg  <= byte_offset_next;
            in_word_reg      <= in_word_next;
            word_begin_reg   <= word_begin_next;
            word_len_reg     <= word_len_next;
            cand_reg         <= cand_next;
            all_word_reg     <= all_word_next;
            first_quote_reg  <= first_quote_next;
            latest_quote_reg <= latest_quote_next;
        end
    end

    // A processed final byte restarts the query at offset zero
    assert property (@(posedge clk) disable iff (!rst_n)
        step && end_of_text |=> (byte_offset_reg == '0) && !in_word_reg)
        else $error("offset not cleared after final byte");

    // An open word always has a nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        in_word_reg |-> (word_len_reg != '0))
        else $error("open word with zero length");

    // No open word means the word state is at rest
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_word_reg |-> (word_len_reg == '0) && (cand_reg == '1) && all_word_reg)
        else $error("word state not at rest between words");

endmodule

[hw/rtl/sql_word_token_classifier.sv]
// ============================================================================
// sql_word_token_classifier
// Splits a byte stream of query text into words and classifies each word.
// ============================================================================
// Query text enters one byte per word on the slave stream, with tlast on the
// final byte of the query. The block takes a new byte every cycle: a byte
// sits in the input register while the word state is updated and, if it
// ends a word or the query, the result is loaded into the output register,
// which presents it on the master stream. Only a full output register with
// the master side stalled holds a byte back, and a byte that causes no
// result moves on even then. Whitespace (space, tab, LF, VT, FF, CR) closes
// the open word; the final byte closes the query and always yields one
// result with tlast set, with tuser low when no word was open. Keywords
// (SELECT FROM WHERE AND OR BETWEEN) and the operators = > >= < <= != match
// case-sensitively; other words of letters, digits and underscores are
// columns, quoted words are literals, the rest unknown. Start offset and
// length saturate at 65535. Offsets restart at zero after each final
// byte.
// ============================================================================
module sql_word_token_classifier
    import swtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [3:0] token_kind, [19:4] token_start,
                                        // [35:20] token_length, [39:36] zero
    output logic        m_axis_tuser,   // [0] token_present
    output logic        m_axis_tlast    // query_done
);

    // Input register
    logic         in_valid_reg;
    logic [7:0]   in_char_reg;
    logic         in_last_reg;

    // Output register
    logic         out_valid_reg;
    swtc_result_t out_reg;

    swtc_result_t result;
    logic         out_free;
    logic         process;

    swtc_scan u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (process),
        .char_byte   (in_char_reg),
        .end_of_text (in_last_reg),
        .result      (result)
    );

    // Advance the held byte when its result, if any, has a place to go
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && (!result.emit || out_free);
    assign s_axis_tready = !in_valid_reg || process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= process && result.emit;
    end

    // Load the result register when it is free
    always_ff @(posedge clk)
    begin
        if (out_free && process && result.emit)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg.length, out_reg.start, out_reg.kind};
    assign m_axis_tuser  = out_reg.present;
    assign m_axis_tlast  = out_reg.done;

    // A result without a word only comes from the final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("empty result without query end");

    // A result without a word carries zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0))
        else $error("empty result with nonzero fields");

    // A word result always has a nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[35:20] != '0))
        else $error("word result with zero length");

    // A held byte that cannot advance stays in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !process |=> in_valid_reg && $stable(in_char_reg)
                                     && $stable(in_last_reg))
        else $error("stalled input byte lost");

endmodule
